>>> rtl/ctbq_pkg.sv
`default_nettype none

package ctbq_pkg;

	// input item selector, travels on the slave tuser
	typedef enum logic [2:0] {
		ACT_INIT    = 3'd0,
		ACT_SEND    = 3'd1,
		ACT_FLUSH   = 3'd2,
		ACT_CLRSYNC = 3'd3,
		ACT_STATUS  = 3'd4
	} action_t;

	localparam logic [1:0] RC_OK       = 2'd0;
	localparam logic [1:0] RC_ILLEGAL  = 2'd1;
	localparam logic [1:0] RC_OVERFLOW = 2'd2;

	// error flag bit positions
	localparam int EB_TX_WARN    = 0;
	localparam int EB_TX_PASSIVE = 1;
	localparam int EB_BUS_OFF    = 2;
	localparam int EB_TX_OVF     = 3;
	localparam int EB_PDO_LATE   = 4;
	localparam int EB_RX_WARN    = 5;
	localparam int EB_RX_PASSIVE = 6;

	localparam logic [11:0] ID_MASK   = 12'h7ff;
	localparam logic [11:0] RTR_BIT   = 12'h800;
	localparam logic [3:0]  MAX_BYTES = 4'd8;
	localparam int          MAX_OUT   = 16;

	localparam int S_TDATA_W = 96;
	localparam int M_TDATA_W = 96;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic single;
		logic fl_begin;
		logic fl_read;
		logic fl_emit;
		logic last_frame;
		logic fl_empty;
		logic cs_begin;
		logic cs_step;
		logic cs_finish;
	} ctbq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		action_t    action;
		logic       hit;
		logic [4:0] lim;
		logic       out_free;
	} ctbq_sts_t;

	// keeps bytes below len, len of 8 or more keeps all
	function automatic logic [63:0] byte_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			m[8*b +: 8] = ({1'b0, 3'(b)} < len) ? 8'hff : 8'h00;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ctbq_ram.sv
`default_nettype none

module ctbq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/ctbq_ctrl.sv
`default_nettype none

module ctbq_ctrl #(
	parameter int TX_ENTRIES = 16,
	parameter int CW = $clog2(TX_ENTRIES + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire ctbq_pkg::ctbq_sts_t sts,
	output ctbq_pkg::ctbq_cmd_t     cmd,
	output logic [CW-1:0]           walk
);
	import ctbq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SINGLE,
		ST_FL_SCAN,
		ST_FL_EMIT,
		ST_FL_EMPTY,
		ST_CS_WALK,
		ST_CS_DONE
	} state_t;

	state_t        state_q;
	logic [CW-1:0] walk_q;
	logic [4:0]    cnt_q;
	logic          fl_done;

	assign walk          = walk_q;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign fl_done       = (cnt_q == sts.lim) || (walk_q == CW'(TX_ENTRIES));

	always_comb begin
		cmd            = '0;
		cmd.capture    = (state_q == ST_IDLE) && s_axis_tvalid;
		cmd.single     = (state_q == ST_SINGLE) && sts.out_free;
		cmd.fl_begin   = (state_q == ST_DISPATCH) && (sts.action == ACT_FLUSH);
		cmd.cs_begin   = (state_q == ST_DISPATCH) && (sts.action == ACT_CLRSYNC);
		cmd.fl_read    = (state_q == ST_FL_SCAN) && !fl_done && sts.hit;
		cmd.fl_emit    = (state_q == ST_FL_EMIT) && sts.out_free;
		cmd.last_frame = (5'(cnt_q + 5'd1) == sts.lim);
		cmd.fl_empty   = (state_q == ST_FL_EMPTY) && sts.out_free;
		cmd.cs_step    = (state_q == ST_CS_WALK);
		cmd.cs_finish  = (state_q == ST_CS_DONE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			walk_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					walk_q <= '0;
					cnt_q  <= '0;
					case (sts.action)
						ACT_FLUSH:   state_q <= ST_FL_SCAN;
						ACT_CLRSYNC: state_q <= ST_CS_WALK;
						default:     state_q <= ST_SINGLE;
					endcase
				end
				ST_SINGLE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FL_SCAN: begin
					if (fl_done) begin
						state_q <= (cnt_q == 5'd0) ? ST_FL_EMPTY : ST_IDLE;
					end else if (sts.hit) begin
						state_q <= ST_FL_EMIT;
					end else begin
						walk_q <= walk_q + CW'(1);
					end
				end
				ST_FL_EMIT: begin
					if (sts.out_free) begin
						cnt_q   <= cnt_q + 5'd1;
						walk_q  <= walk_q + CW'(1);
						state_q <= ST_FL_SCAN;
					end
				end
				ST_FL_EMPTY: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CS_WALK: begin
					walk_q <= walk_q + CW'(1);
					if (walk_q == CW'(TX_ENTRIES - 1)) begin
						state_q <= ST_CS_DONE;
					end
				end
				ST_CS_DONE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// never emit more frames than the limit taken at flush start
	a_flush_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FL_EMIT |-> cnt_q < sts.lim)
		else $error("flush emits beyond its limit");

	// clear-sync walk stays within the table
	a_cs_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CS_WALK |-> walk_q < CW'(TX_ENTRIES))
		else $error("clear-sync walk out of range");

	// the walk pointer stops one past the last entry
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		walk_q <= CW'(TX_ENTRIES))
		else $error("walk pointer out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/ctbq_dpath.sv
`default_nettype none

module ctbq_dpath #(
	parameter int TX_ENTRIES = 16,
	parameter int CW = $clog2(TX_ENTRIES + 1),
	parameter int IW = (TX_ENTRIES > 1) ? $clog2(TX_ENTRIES) : 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [ctbq_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input  wire logic [2:0]                     s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [ctbq_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	output logic                                m_axis_tuser,
	output logic                                m_axis_tlast,
	input  wire ctbq_pkg::ctbq_cmd_t            cmd,
	output ctbq_pkg::ctbq_sts_t                 sts,
	input  wire logic [CW-1:0]                  walk
);
	import ctbq_pkg::*;

	// captured item
	action_t     act_q;
	logic [3:0]  idx_q;
	logic [10:0] ident_q;
	logic        rtr_q;
	logic [3:0]  len_q;
	logic        sync_q;
	logic [63:0] payload_q;
	logic [4:0]  fifo_q;
	logic        boff_q;
	logic        warn_q;
	logic        pass_q;

	// entry table, bytes live in the RAM
	logic [11:0] id_q       [TX_ENTRIES];
	logic [3:0]  len_tab_q  [TX_ENTRIES];
	logic        pend_q     [TX_ENTRIES];
	logic        sync_tab_q [TX_ENTRIES];

	logic [CW-1:0] pt_q;
	logic          inhibit_q;
	logic          first_q;
	logic [6:0]    ef_q;
	logic          late_q;
	logic [4:0]    lim_q;
	logic [CW-1:0] endq_q;

	logic          m_tvalid_q;
	logic          o_fvalid_q;
	logic [10:0]   o_ident_q;
	logic [3:0]    o_len_q;
	logic [63:0]   o_data_q;
	logic [1:0]    o_code_q;
	logic [6:0]    o_ef_q;
	logic [4:0]    o_queued_q;
	logic          o_recover_q;
	logic          o_last_q;

	logic [IW-1:0] sa;
	logic [IW-1:0] wa;
	logic          idx_ok;
	logic          out_free;
	logic          out_load;
	logic          cs_hit;
	logic [63:0]   ram_rd;
	logic          ram_we;

	logic          init_wr;
	logic          pend_set;
	logic          pend_clr_sa;
	logic          emit;
	logic [1:0]    code_d;
	logic [6:0]    ef_d;
	logic [CW-1:0] pt_d;
	logic          inhibit_d;
	logic          first_d;
	logic [4:0]    lim_d;

	logic          o_fvalid_d;
	logic [10:0]   o_ident_d;
	logic [3:0]    o_len_d;
	logic [63:0]   o_data_d;
	logic [1:0]    o_code_d;
	logic [6:0]    o_ef_d;
	logic [4:0]    o_queued_d;
	logic          o_recover_d;
	logic          o_last_d;

	assign sa       = IW'(idx_q);
	assign wa       = walk[IW-1:0];
	assign idx_ok   = int'(idx_q) < TX_ENTRIES;
	assign out_free = !m_tvalid_q || m_axis_tready;
	assign out_load = cmd.single || cmd.fl_emit || cmd.fl_empty || cmd.cs_finish;
	assign cs_hit   = pend_q[wa] && sync_tab_q[wa];

	assign sts.action   = act_q;
	assign sts.hit      = pend_q[wa];
	assign sts.lim      = lim_q;
	assign sts.out_free = out_free;

	ctbq_ram #(
		.WIDTH (64),
		.DEPTH (TX_ENTRIES)
	) u_bytes (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sa),
		.wdata (payload_q),
		.re    (cmd.fl_read),
		.raddr (wa),
		.rdata (ram_rd)
	);

	// flush limit: frames pending, FIFO room and per-step cap
	always_comb begin
		int l;
		l = (int'(pt_q) < int'(fifo_q)) ? int'(pt_q) : int'(fifo_q);
		if (l > MAX_OUT) begin
			l = MAX_OUT;
		end
		lim_d = 5'(l);
	end

	// next state of the scalar state
	always_comb begin
		init_wr     = 1'b0;
		pend_set    = 1'b0;
		pend_clr_sa = 1'b0;
		emit        = 1'b0;
		ram_we      = 1'b0;
		code_d      = RC_OK;
		ef_d        = ef_q;
		pt_d        = pt_q;
		inhibit_d   = inhibit_q;
		first_d     = first_q;
		if (cmd.single) begin
			case (act_q)
				ACT_INIT: begin
					if (!idx_ok || len_q > MAX_BYTES) begin
						code_d = RC_ILLEGAL;
					end else begin
						init_wr = 1'b1;
						if (pend_q[sa]) begin
							pend_clr_sa = 1'b1;
							pt_d        = pt_q - CW'(1);
						end
					end
				end
				ACT_SEND: begin
					if (!idx_ok || (id_q[sa] & RTR_BIT) != 12'd0) begin
						code_d = RC_ILLEGAL;
					end else begin
						ram_we = 1'b1;
						if (pend_q[sa]) begin
							code_d = RC_OVERFLOW;
							if (!first_q) begin
								ef_d[EB_TX_OVF] = 1'b1;
							end
						end
						if (pt_q == '0 && fifo_q != 5'd0) begin
							emit      = 1'b1;
							inhibit_d = sync_tab_q[sa];
							first_d   = 1'b0;
						end else if (!pend_q[sa]) begin
							pend_set = 1'b1;
							pt_d     = pt_q + CW'(1);
						end
					end
				end
				ACT_STATUS: begin
					ef_d[EB_TX_WARN]    = warn_q;
					ef_d[EB_RX_WARN]    = warn_q;
					ef_d[EB_TX_PASSIVE] = pass_q;
					ef_d[EB_RX_PASSIVE] = pass_q;
					ef_d[EB_BUS_OFF]    = boff_q;
				end
				default: code_d = RC_ILLEGAL;
			endcase
		end
		if (cmd.fl_emit) begin
			pt_d      = pt_q - CW'(1);
			inhibit_d = sync_tab_q[wa];
			first_d   = 1'b0;
		end
		if (cmd.cs_begin) begin
			inhibit_d = 1'b0;
		end
		if (cmd.cs_step && cs_hit) begin
			pt_d = pt_q - CW'(1);
		end
		if (cmd.cs_finish && late_q) begin
			ef_d[EB_PDO_LATE] = 1'b1;
		end
	end

	// result content
	always_comb begin
		o_fvalid_d  = 1'b0;
		o_ident_d   = '0;
		o_len_d     = '0;
		o_data_d    = '0;
		o_code_d    = code_d;
		o_ef_d      = ef_d;
		o_queued_d  = 5'(pt_d);
		o_recover_d = 1'b0;
		o_last_d    = 1'b1;
		if (cmd.single) begin
			o_recover_d = (act_q == ACT_STATUS) && boff_q;
			if (emit) begin
				o_fvalid_d = 1'b1;
				o_ident_d  = 11'(id_q[sa] & ID_MASK);
				o_len_d    = len_tab_q[sa];
				o_data_d   = payload_q & byte_mask(len_tab_q[sa]);
			end
		end
		if (cmd.fl_emit) begin
			o_fvalid_d = 1'b1;
			o_ident_d  = 11'(id_q[wa] & ID_MASK);
			o_len_d    = len_tab_q[wa];
			o_data_d   = ram_rd & byte_mask(len_tab_q[wa]);
			o_queued_d = 5'(endq_q);
			o_last_d   = cmd.last_frame;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q     <= action_t'(s_axis_tuser);
			idx_q     <= s_axis_tdata[3:0];
			ident_q   <= s_axis_tdata[14:4];
			rtr_q     <= s_axis_tdata[15];
			len_q     <= s_axis_tdata[19:16];
			sync_q    <= s_axis_tdata[20];
			payload_q <= s_axis_tdata[84:21];
			fifo_q    <= s_axis_tdata[89:85];
			boff_q    <= s_axis_tdata[90];
			warn_q    <= s_axis_tdata[91];
			pass_q    <= s_axis_tdata[92];
		end
		if (cmd.fl_begin) begin
			lim_q  <= lim_d;
			endq_q <= pt_q - CW'(lim_d);
		end
		if (out_load) begin
			o_fvalid_q  <= o_fvalid_d;
			o_ident_q   <= o_ident_d;
			o_len_q     <= o_len_d;
			o_data_q    <= o_data_d;
			o_code_q    <= o_code_d;
			o_ef_q      <= o_ef_d;
			o_queued_q  <= o_queued_d;
			o_recover_q <= o_recover_d;
			o_last_q    <= o_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TX_ENTRIES; i++) begin
				id_q[i]       <= '0;
				len_tab_q[i]  <= '0;
				pend_q[i]     <= 1'b0;
				sync_tab_q[i] <= 1'b0;
			end
			pt_q       <= '0;
			inhibit_q  <= 1'b0;
			first_q    <= 1'b1;
			ef_q       <= '0;
			late_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (init_wr) begin
				id_q[sa]       <= {rtr_q, ident_q};
				len_tab_q[sa]  <= len_q;
				sync_tab_q[sa] <= sync_q;
			end
			if (pend_set) begin
				pend_q[sa] <= 1'b1;
			end
			if (pend_clr_sa) begin
				pend_q[sa] <= 1'b0;
			end
			if (cmd.fl_emit || (cmd.cs_step && cs_hit)) begin
				pend_q[wa] <= 1'b0;
			end
			if (cmd.cs_begin) begin
				late_q <= inhibit_q;
			end else if (cmd.cs_step && cs_hit) begin
				late_q <= 1'b1;
			end
			pt_q      <= pt_d;
			inhibit_q <= inhibit_d;
			first_q   <= first_d;
			ef_q      <= ef_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tuser  = o_fvalid_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {2'b00, o_recover_q, o_queued_q, o_ef_q, o_code_q,
		o_data_q, o_len_q, o_ident_q};

`ifndef SYNTHESIS
	// pending count can never pass the table size
	a_pt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pt_q <= CW'(TX_ENTRIES))
		else $error("pending count out of range");

	// a result is only loaded when the output stage can take it
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_axis_tready))
		else $error("result overwritten before transfer");

	// a frame on its way out never claims more than eight bytes
	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && o_fvalid_q |-> o_len_q <= MAX_BYTES)
		else $error("frame length above eight");
`endif

endmodule

`default_nettype wire

>>> rtl/can_tx_buffer_queue.sv
// Transmit buffer queue for a classic CAN driver.
// Slave stream: one transaction per action. tuser carries the action code,
// tdata the arguments. Master stream: one transaction per frame handed to
// the hardware FIFO, or a single frame-less transaction (tuser low) when the
// action sends nothing; tlast marks the final transaction of an action.
// Status fields (result code, error bits, queue count, recovery request)
// in every transaction of an action show the state at the end of it.
// Timing: one action at a time. Init, send, status and illegal actions pass
// the dispatch and single states from acceptance to the result in the output
// register, the single state waiting while the output register is full; the
// next action is taken only after the result is loaded. A flush walks the
// table one entry per cycle, stopping at each pending entry for the
// registered data RAM read and its frame. Clear-sync walks the whole table,
// clearing the pending entries that carry the sync flag.
// The slave side is ready again in the cycle after the last result is loaded
// (after a further scan state if a flush sent frames), while the result may
// still wait in the output register. When the receiver stalls, a flush holds
// with the next frame ready and the table untouched until it is taken.
// Reset clears the table, queue count and flags; the first-message flag is
// set. The data RAM holds no reset value: bytes are written by each send.
`default_nettype none

module can_tx_buffer_queue #(
	parameter int TX_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side: one action per transaction
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// index[3:0] ident[14:4] rtr[15] length[19:16] sync_flag[20]
	// payload[84:21] fifo_free[89:85] bus_off[90] warning[91]
	// error_passive[92], zero pad [95:93]
	input  wire logic [95:0] s_axis_tdata,
	// action[2:0]
	input  wire logic [2:0]  s_axis_tuser,
	// master side: results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// frame_ident[10:0] frame_length[14:11] frame_data[78:15]
	// result_code[80:79] error_bits[87:81] queued[92:88]
	// recover_request[93], zero pad [95:94]
	output logic [95:0]      m_axis_tdata,
	// frame_valid
	output logic             m_axis_tuser,
	output logic             m_axis_tlast
);
	import ctbq_pkg::*;

	localparam int CW = $clog2(TX_ENTRIES + 1);

	ctbq_cmd_t     cmd;
	ctbq_sts_t     sts;
	logic [CW-1:0] walk;

	// sequencer: handshake on the slave side, table walks, flush counting
	ctbq_ctrl #(
		.TX_ENTRIES (TX_ENTRIES)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd),
		.walk          (walk)
	);

	// entry table, flags, data RAM and the output register
	ctbq_dpath #(
		.TX_ENTRIES (TX_ENTRIES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cmd           (cmd),
		.sts           (sts),
		.walk          (walk)
	);

endmodule

`default_nettype wire
